FILE: rtl/tte_pkg.sv
// ----------------------------------------------------------------------------
// tte_pkg
// Shared sizes, outcome codes and the control/status bundles of the
// track time event clusterer.
// ----------------------------------------------------------------------------
package tte_pkg;

  localparam int MAX_EVENTS = 64;
  localparam int COUNT_BITS = 16;
  localparam int TIME_W     = 32;
  localparam int WIN_W      = 16;
  localparam int IDX_W      = $clog2(MAX_EVENTS);
  localparam int USED_W     = IDX_W + 1;
  localparam int PROD_W     = TIME_W + COUNT_BITS;
  localparam int NUM_W      = PROD_W + 1;
  localparam int DIV_W      = COUNT_BITS + 1;
  localparam int STEP_W     = $clog2(TIME_W);

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(48);

  typedef enum logic [1:0] {
    OUT_MATCH = 2'd0,
    OUT_NEW   = 2'd1,
    OUT_DROP  = 2'd2
  } outcome_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic mul;
    logic add;
    logic div;
    logic fin_match;
    logic fin_new;
    logic fin_drop;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_end;
    logic full;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/tte_in_if.sv
// ----------------------------------------------------------------------------
// tte_in_if
// Valid/ready channel that carries one track timestamp word.
// ----------------------------------------------------------------------------
interface tte_in_if;
  logic                        valid;
  logic                        ready;
  logic [tte_pkg::TIME_W-1:0]  track_time;

  modport source (output valid, output track_time, input ready);
  modport sink   (input valid, input track_time, output ready);
endinterface

FILE: rtl/tte_out_if.sv
// ----------------------------------------------------------------------------
// tte_out_if
// Valid/ready channel that carries one clustering result word.
// ----------------------------------------------------------------------------
interface tte_out_if;
  logic                            valid;
  logic                            ready;
  tte_pkg::outcome_t               outcome;
  logic [tte_pkg::IDX_W-1:0]       event_index;
  logic [tte_pkg::TIME_W-1:0]      event_mean_time;
  logic [tte_pkg::COUNT_BITS-1:0]  event_track_count;

  modport source (output valid, output outcome, output event_index,
                  output event_mean_time, output event_track_count, input ready);
  modport sink   (input valid, input outcome, input event_index,
                  input event_mean_time, input event_track_count, output ready);
endinterface

FILE: rtl/tte_ctrl.sv
// ----------------------------------------------------------------------------
// tte_ctrl
// Sequencer: search, then on a match multiply, add and serial divide; commit the match, new-entry or drop result.
// ----------------------------------------------------------------------------
module tte_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tte_pkg::sts_t sts,
  output tte_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_ADD,
    ST_DIV,
    ST_FIN_MATCH,
    ST_FIN_NEW,
    ST_FIN_DROP
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        priority if (sts.hit) state_next = ST_MUL;
        else if (sts.scan_end) state_next = sts.full ? ST_FIN_DROP : ST_FIN_NEW;
      end
      ST_MUL: state_next = ST_ADD;
      ST_ADD: state_next = ST_DIV;
      ST_DIV: begin
        if (sts.div_last) state_next = ST_FIN_MATCH;
      end
      ST_FIN_MATCH, ST_FIN_NEW, ST_FIN_DROP: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.load      = (state == ST_IDLE) && in_valid;
    cmd.scan      = (state == ST_SCAN);
    cmd.mul       = (state == ST_MUL);
    cmd.add       = (state == ST_ADD);
    cmd.div       = (state == ST_DIV);
    cmd.fin_match = (state == ST_FIN_MATCH) && sts.out_free;
    cmd.fin_new   = (state == ST_FIN_NEW) && sts.out_free;
    cmd.fin_drop  = (state == ST_FIN_DROP) && sts.out_free;
  end

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/tte_dpath.sv
// ----------------------------------------------------------------------------
// tte_dpath
// Cluster table, window compare, mean update arithmetic and result register.
// ----------------------------------------------------------------------------
module tte_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  tte_pkg::cmd_t                 cmd,
  output tte_pkg::sts_t                 sts,
  input  logic                          cfg_we,
  input  logic [tte_pkg::WIN_W-1:0]     cfg_data,
  input  logic [tte_pkg::TIME_W-1:0]    track_time,
  tte_out_if.source                     result
);

  // cluster table
  logic [tte_pkg::TIME_W-1:0]     mean_mem  [tte_pkg::MAX_EVENTS];
  logic [tte_pkg::COUNT_BITS-1:0] count_mem [tte_pkg::MAX_EVENTS];

  logic [tte_pkg::WIN_W-1:0]      window;
  logic [tte_pkg::USED_W-1:0]     used;
  logic [tte_pkg::TIME_W-1:0]     t_reg;
  logic [tte_pkg::USED_W-1:0]     scan_idx;
  logic [tte_pkg::IDX_W-1:0]      cmp_idx;
  logic                           cmp_valid;
  logic [tte_pkg::TIME_W-1:0]     mean_q;
  logic [tte_pkg::COUNT_BITS-1:0] count_q;
  logic [tte_pkg::PROD_W-1:0]     prod;
  logic [tte_pkg::DIV_W-1:0]      divisor;
  logic [tte_pkg::DIV_W-1:0]      rem;
  logic [tte_pkg::TIME_W-1:0]     qr;
  logic [tte_pkg::STEP_W-1:0]     div_cnt;
  logic [tte_pkg::COUNT_BITS-1:0] cnt_new;
  logic                           out_valid;

  logic                           rd_en;
  logic [tte_pkg::TIME_W-1:0]     diff;
  logic                           hit;
  logic [tte_pkg::NUM_W-1:0]      num;
  logic [tte_pkg::DIV_W:0]        rem_sh;
  logic                           q_bit;
  logic [tte_pkg::DIV_W-1:0]      rem_next;
  logic                           wr_en;
  logic [tte_pkg::IDX_W-1:0]      wr_addr;
  logic [tte_pkg::TIME_W-1:0]     wr_mean;
  logic [tte_pkg::COUNT_BITS-1:0] wr_count;

  // window compare on the entry read last cycle
  assign diff = (t_reg >= mean_q) ? (t_reg - mean_q) : (mean_q - t_reg);
  assign hit  = cmp_valid && (diff < tte_pkg::TIME_W'(window));

  // hold the read data once an entry matches
  assign rd_en = cmd.scan && !hit && (scan_idx < used);

  assign num = tte_pkg::NUM_W'(prod) + tte_pkg::NUM_W'(t_reg);

  // one restoring division step per cycle
  assign rem_sh   = {rem, qr[tte_pkg::TIME_W-1]};
  assign q_bit    = (rem_sh >= {1'b0, divisor});
  assign rem_next = q_bit ? tte_pkg::DIV_W'(rem_sh - {1'b0, divisor})
                          : tte_pkg::DIV_W'(rem_sh);

  assign wr_en    = cmd.fin_match || cmd.fin_new;
  assign wr_addr  = cmd.fin_new ? used[tte_pkg::IDX_W-1:0] : cmp_idx;
  assign wr_mean  = cmd.fin_new ? t_reg : qr;
  assign wr_count = cmd.fin_new ? tte_pkg::COUNT_BITS'(1) : cnt_new;

  always_comb begin
    sts          = '0;
    sts.hit      = hit;
    sts.scan_end = !cmp_valid && (scan_idx >= used);
    sts.full     = (used >= tte_pkg::USED_W'(tte_pkg::MAX_EVENTS));
    sts.div_last = (div_cnt == tte_pkg::STEP_W'(tte_pkg::TIME_W - 1));
    sts.out_free = !out_valid || result.ready;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mean_mem[wr_addr]  <= wr_mean;
      count_mem[wr_addr] <= wr_count;
    end
    if (rd_en) begin
      mean_q  <= mean_mem[scan_idx[tte_pkg::IDX_W-1:0]];
      count_q <= count_mem[scan_idx[tte_pkg::IDX_W-1:0]];
      cmp_idx <= scan_idx[tte_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window    <= tte_pkg::WINDOW_RESET;
      used      <= '0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) window <= cfg_data;
      if (cmd.fin_new) used <= used + tte_pkg::USED_W'(1);
      cmp_valid <= cmd.load ? 1'b0 : rd_en;
      if (cmd.fin_match || cmd.fin_new || cmd.fin_drop) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_reg    <= track_time;
      scan_idx <= '0;
    end else if (rd_en) begin
      scan_idx <= scan_idx + tte_pkg::USED_W'(1);
    end
    if (cmd.mul) prod <= mean_q * count_q;
    if (cmd.add) begin
      rem     <= num[tte_pkg::NUM_W-1:tte_pkg::TIME_W];
      qr      <= num[tte_pkg::TIME_W-1:0];
      divisor <= tte_pkg::DIV_W'(count_q) + tte_pkg::DIV_W'(1);
      cnt_new <= (&count_q) ? count_q : count_q + tte_pkg::COUNT_BITS'(1);
      div_cnt <= '0;
    end
    if (cmd.div) begin
      rem     <= rem_next;
      qr      <= {qr[tte_pkg::TIME_W-2:0], q_bit};
      div_cnt <= div_cnt + tte_pkg::STEP_W'(1);
    end
    unique case (1'b1)
      cmd.fin_match: begin
        result.outcome           <= tte_pkg::OUT_MATCH;
        result.event_index       <= cmp_idx;
        result.event_mean_time   <= qr;
        result.event_track_count <= cnt_new;
      end
      cmd.fin_new: begin
        result.outcome           <= tte_pkg::OUT_NEW;
        result.event_index       <= used[tte_pkg::IDX_W-1:0];
        result.event_mean_time   <= t_reg;
        result.event_track_count <= tte_pkg::COUNT_BITS'(1);
      end
      cmd.fin_drop: begin
        result.outcome           <= tte_pkg::OUT_DROP;
        result.event_index       <= '0;
        result.event_mean_time   <= '0;
        result.event_track_count <= '0;
      end
      default: begin
      end
    endcase
  end

  assign result.valid = out_valid;

endmodule

FILE: rtl/track_time_event_clusterer.sv
// ----------------------------------------------------------------------------
// track_time_event_clusterer
// Sequence: a new or dropped word scans every used entry, then commits; a match
//   at entry k scans up to k, then does a multiply, an add and a 32-step divide.
// Throughput: one word at a time; the serial divider and the one-read-a-cycle
//   table scan set the rate. The next word is taken while a result waits.
// Reset: synchronous rst empties the table and sets the window to 48 (3 ns).
// ----------------------------------------------------------------------------
module track_time_event_clusterer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [tte_pkg::WIN_W-1:0] cfg_data,
  tte_in_if.sink                    track,
  tte_out_if.source                 result
);

  // control and status between the sequencer and the datapath
  tte_pkg::cmd_t cmd;
  tte_pkg::sts_t sts;

  // sequencer: accept a word only when idle, then walk search/update steps
  tte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (track.valid),
    .in_ready (track.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: table memory, compare, multiply-add, divider, result register
  tte_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .track_time (track.track_time),
    .result     (result)
  );

`ifndef SYNTHESIS
  // drop ready right after taking a word; hold it until the word is done
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (track.valid && track.ready) |=> !track.ready)
    else $error("input taken while a word is in progress");

  // a dropped word carries no table entry
  a_drop_fields: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.outcome == tte_pkg::OUT_DROP)
      |-> (result.event_index == '0 && result.event_track_count == '0))
    else $error("dropped result with nonzero fields");

  // a matched or opened entry always counts at least one track
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.outcome == tte_pkg::OUT_MATCH ||
                      result.outcome == tte_pkg::OUT_NEW))
      |-> (result.event_track_count != '0))
    else $error("result entry with zero track count");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the track time event clusterer. A software copy of
// the cluster table predicts the outcome, entry, mean and count of every
// accepted timestamp word. Stimulus runs directed corner cases first, then
// bursts of tracks around live cluster means under several windows, then a
// fill of the whole table and tracks against the full table. Both channels
// idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import tte_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_PRINTS  = 30;

  // One predicted result word, laid out like the output channel.
  typedef struct packed {
    outcome_t                outcome;
    logic [IDX_W-1:0]        index;
    logic [TIME_W-1:0]       mean;
    logic [COUNT_BITS-1:0]   count;
  } cluster_result_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [WIN_W-1:0] cfg_data;

  tte_in_if  track_ch ();
  tte_out_if result_ch ();

  track_time_event_clusterer dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .track    (track_ch),
    .result   (result_ch)
  );

  // --------------------------------------------------------------------------
  // Cluster table copy and the queue of results still owed by the block.
  // --------------------------------------------------------------------------
  logic [TIME_W-1:0]     mean_tab  [MAX_EVENTS];
  logic [COUNT_BITS-1:0] count_tab [MAX_EVENTS];
  int                    used_entries;
  logic [WIN_W-1:0]      win_now;
  cluster_result_t       results_due[$];

  int  err_count;
  int  cycle_count;
  int  tracks_sent;
  int  seen_match;
  int  seen_open;
  int  seen_drop;
  int  window_writes;
  int  max_count_seen;
  bit  tx_quiet;
  bit  rx_quiet;
  int  rx_stall;

  // Assign one timestamp to the table copy and return the result word it owes.
  // The search takes the lowest used entry strictly inside the window; the new
  // mean is the floor of the weighted average, computed on 64 bits so that the
  // product of a full mean and a full count cannot wrap.
  function automatic cluster_result_t cluster_assign(input logic [TIME_W-1:0] t);
    cluster_result_t r;
    logic [TIME_W-1:0] sep;
    logic [63:0]       cnt;
    logic [63:0]       sum;
    int                i;
    r.outcome = OUT_DROP;
    r.index   = '0;
    r.mean    = '0;
    r.count   = '0;
    for (i = 0; i < used_entries; i++) begin
      sep = (t >= mean_tab[i]) ? t - mean_tab[i] : mean_tab[i] - t;
      if (sep < TIME_W'(win_now)) begin
        cnt = 64'(count_tab[i]);
        sum = 64'(mean_tab[i]) * cnt + 64'(t);
        mean_tab[i] = TIME_W'(sum / (cnt + 64'd1));
        // Hold the count at its ceiling once saturated; the mean still moves.
        if (count_tab[i] != '1) count_tab[i] = count_tab[i] + COUNT_BITS'(1);
        r.outcome = OUT_MATCH;
        r.index   = IDX_W'(i);
        r.mean    = mean_tab[i];
        r.count   = count_tab[i];
        return r;
      end
    end
    // Table full and nothing matched: drop with all-zero fields.
    if (used_entries >= MAX_EVENTS) return r;
    mean_tab[used_entries]  = t;
    count_tab[used_entries] = COUNT_BITS'(1);
    r.outcome = OUT_NEW;
    r.index   = IDX_W'(used_entries);
    r.mean    = t;
    r.count   = COUNT_BITS'(1);
    used_entries++;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, cycle limit.
  // --------------------------------------------------------------------------
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, results_due.size());
      $display("[track_time_event_clusterer] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, most stalls short, a few long.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rx_quiet || rx_stall == 0) begin
      result_ch.ready = 1'b1;
      if (!rx_quiet) begin
        case ($urandom_range(0, 99)) inside
          [0:59]:  rx_stall = 0;
          [60:91]: rx_stall = $urandom_range(1, 3);
          default: rx_stall = $urandom_range(10, 60);
        endcase
      end
    end else begin
      result_ch.ready = 1'b0;
      rx_stall--;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  // Compare every accepted result word with the oldest prediction.
  always @(posedge clk) begin : result_check
    cluster_result_t want;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (results_due.size() == 0) begin
        report_mismatch("unexpected result word", 64'(result_ch.outcome), 64'd0);
      end else begin
        want = results_due.pop_front();
        if (result_ch.outcome !== want.outcome)
          report_mismatch("outcome", 64'(result_ch.outcome), 64'(want.outcome));
        if (result_ch.event_index !== want.index)
          report_mismatch("event_index", 64'(result_ch.event_index), 64'(want.index));
        if (result_ch.event_mean_time !== want.mean)
          report_mismatch("event_mean_time", 64'(result_ch.event_mean_time),
                          64'(want.mean));
        if (result_ch.event_track_count !== want.count)
          report_mismatch("event_track_count", 64'(result_ch.event_track_count),
                          64'(want.count));
        case (want.outcome)
          OUT_MATCH: seen_match++;
          OUT_NEW:   seen_open++;
          default:   seen_drop++;
        endcase
        if (int'(want.count) > max_count_seen) max_count_seen = int'(want.count);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Track side helpers. All of them start and end at a falling edge.
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    if (tx_quiet) return 0;
    case ($urandom_range(0, 99)) inside
      [0:54]:  return 0;
      [55:89]: return $urandom_range(1, 4);
      default: return $urandom_range(15, 80);
    endcase
  endfunction

  // Offer one timestamp word and hold it until taken. Valid stays high on
  // return so that back-to-back words need no low cycle between them.
  task automatic send_track(input logic [TIME_W-1:0] t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      track_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    track_ch.valid      = 1'b1;
    track_ch.track_time = t;
    @(posedge clk);
    while (track_ch.ready !== 1'b1) @(posedge clk);
    results_due.insert(results_due.size(), cluster_assign(t));
    tracks_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic drain_tracks();
    track_ch.valid = 1'b0;
    while (results_due.size() != 0) @(negedge clk);
  endtask

  // Write the window only with the block idle; every word owes a result, so
  // an empty queue means nothing is in flight.
  task automatic set_window(input logic [WIN_W-1:0] w);
    drain_tracks();
    repeat (4) @(negedge clk);
    cfg_data = w;
    cfg_we   = 1'b1;
    @(negedge clk);
    cfg_we   = 1'b0;
    win_now  = w;
    window_writes++;
  endtask

  // A timestamp within the current window of a given center (wraps at 32 bits).
  function automatic logic [TIME_W-1:0] near(input logic [TIME_W-1:0] center);
    int span;
    int off;
    if (win_now <= 1) return center;
    span = int'(win_now) - 1;
    off  = int'($urandom_range(0, 2 * span)) - span;
    return center + TIME_W'(off);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset window: first entry, a match, a track just outside the window, the
  // top of the time range, and a track that fits two entries at once.
  task automatic test_basic_matching();
    send_track(32'd0);
    send_track(32'd47);            // inside the 3 ns window of entry 0
    send_track(32'd71);            // exactly one window away: opens entry 1
    send_track(32'hFFFF_FFFF);
    send_track(32'hFFFF_FFF0);     // sum of the two needs 33 bits
    send_track(32'd47);            // fits entries 0 and 1: lowest index wins
    send_track(32'd0);
    drain_tracks();
  endtask

  // Narrowest, zero and widest windows.
  task automatic test_window_extremes();
    set_window(16'd1);
    send_track(mean_tab[1]);       // distance 0 is inside a window of 1
    send_track(mean_tab[1] + 1);   // distance 1 is not
    set_window(16'd0);
    send_track(mean_tab[0]);       // nothing is strictly below 0: opens
    send_track(32'h8000_0000);
    set_window(16'hFFFF);
    send_track(mean_tab[0] + 32'd65534);
    send_track(mean_tab[0] - 32'd65534);
    send_track(32'h7FFF_FFFF);
    drain_tracks();
  endtask

  // Bursts of tracks around live cluster means, with some fresh centers and
  // some plain noise, over several windows and idling patterns.
  task automatic test_random_clusters(input int phases, input int per_phase);
    logic [WIN_W-1:0]  w;
    logic [TIME_W-1:0] center;
    int                sent;
    int                burst;
    int                k;
    bit                drained;
    for (int p = 0; p < phases; p++) begin
      case (p % 8)
        0:       w = WINDOW_RESET;
        1:       w = 16'hFFFF;
        2:       w = 16'h5555;
        3:       w = 16'hAAAA;
        4:       w = 16'd1;
        5:       w = WIN_W'($urandom_range(2, 200));
        default: w = WIN_W'($urandom_range(1, 65535));
      endcase
      set_window(w);
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      sent    = 0;
      drained = 1'b0;
      while (sent < per_phase) begin
        k = $urandom_range(0, 99);
        if (k < 8 || used_entries == 0) begin
          // Noise: a lone track anywhere in the range.
          send_track($urandom);
          sent++;
        end else begin
          center = (k < 16) ? $urandom : mean_tab[$urandom_range(0, used_entries - 1)];
          burst  = $urandom_range(2, 8);
          for (int b = 0; b < burst && sent < per_phase; b++) begin
            send_track(near(center));
            sent++;
          end
        end
        // Once per phase, hold the sender until the block has caught up.
        if (!drained && sent >= per_phase / 2) begin
          drain_tracks();
          drained = 1'b1;
        end
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    drain_tracks();
  endtask

  // Zero window opens an entry per track until the table is full; after that
  // every track is dropped, even one that sits on an existing mean.
  task automatic test_table_overflow();
    set_window(16'd0);
    while (used_entries < MAX_EVENTS) send_track($urandom);
    send_track(mean_tab[MAX_EVENTS - 1]);
    for (int i = 0; i < 10; i++) send_track($urandom);
    drain_tracks();
  endtask

  // Full table: tracks near existing means still match, the rest drop.
  task automatic test_full_table(input int n);
    set_window(WINDOW_RESET);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 7)
        send_track(near(mean_tab[$urandom_range(0, MAX_EVENTS - 1)]));
      else
        send_track($urandom);
      if (i == n / 2) set_window(WIN_W'($urandom_range(1, 65535)));
    end
    drain_tracks();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_data            = '0;
    track_ch.valid      = 1'b0;
    track_ch.track_time = '0;
    result_ch.ready     = 1'b0;
    used_entries        = 0;
    win_now             = WINDOW_RESET;
    err_count           = 0;
    cycle_count         = 0;
    tracks_sent         = 0;
    seen_match          = 0;
    seen_open           = 0;
    seen_drop           = 0;
    window_writes       = 0;
    max_count_seen      = 0;
    tx_quiet            = 1'b0;
    rx_quiet            = 1'b0;
    rx_stall            = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_basic_matching();
    test_window_extremes();
    test_random_clusters(8, 50);
    test_table_overflow();
    test_full_table(60);

    // Let anything late show up as an unexpected word: the wait covers a full-table
    // scan plus the divide.
    drain_tracks();
    repeat (150) @(posedge clk);

    $display("%0d tracks: %0d matched, %0d opened, %0d dropped; %0d window writes",
             tracks_sent, seen_match, seen_open, seen_drop, window_writes);
    $display("table filled to %0d entries, highest track count %0d",
             used_entries, max_count_seen);
    if (err_count == 0 && results_due.size() == 0) begin
      $display("[track_time_event_clusterer] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", err_count, results_due.size());
      $display("[track_time_event_clusterer] ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/tte_pkg.sv
rtl/tte_in_if.sv
rtl/tte_out_if.sv
rtl/tte_ctrl.sv
rtl/tte_dpath.sv
rtl/track_time_event_clusterer.sv
tb/tb_top.sv
